/* design/bce_pkg.sv */
// Bezier curve evaluator package: beat types, op and status codes, fixed-point
// widths and the binomial coefficient table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bce_pkg;

  // field widths
  localparam int OP_W     = 2;
  localparam int COORD_W  = 16;
  localparam int INDEX_W  = 10;
  localparam int STEPS_W  = 10;
  localparam int STATUS_W = 2;

  // op codes
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_EVAL   = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FEW_POINTS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

  // sample_steps after reset
  localparam logic [STEPS_W-1:0] STEPS_RESET = 10'd100;

  // Q1.16 arithmetic
  localparam int              Q16_W    = 17;
  localparam logic [Q16_W-1:0] Q16_ONE = 17'h10000;
  localparam int              RND_HALF = 32768;

  // shared multiplier: unsigned A, signed B
  localparam int MUL_A_W = 26;
  localparam int MUL_B_W = 18;
  localparam int MUL_W   = MUL_A_W + 1 + MUL_B_W;
  localparam int PROD_W  = 42;
  localparam int ACC_W   = 46;

  // restoring divider for t = (k * 2^16 + s/2) / s
  localparam int DIV_STEPS = Q16_W;
  localparam int DIV_CNT_W = 5;
  localparam int NUM_W     = INDEX_W + 16;

  // binomial coefficients C(n, j) for n up to 12
  localparam int BINOM_N     = 13;
  localparam int BINOM_W     = 10;
  localparam int BINOM_IDX_W = 4;
  localparam logic [BINOM_W-1:0] BINOM_TAB [BINOM_N][BINOM_N] = '{
    '{10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
    '{10'd1, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
    '{10'd1, 10'd2, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
    '{10'd1, 10'd3, 10'd3, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
    '{10'd1, 10'd4, 10'd6, 10'd4, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
    '{10'd1, 10'd5, 10'd10, 10'd10, 10'd5, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
      10'd0},
    '{10'd1, 10'd6, 10'd15, 10'd20, 10'd15, 10'd6, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
      10'd0},
    '{10'd1, 10'd7, 10'd21, 10'd35, 10'd35, 10'd21, 10'd7, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0,
      10'd0},
    '{10'd1, 10'd8, 10'd28, 10'd56, 10'd70, 10'd56, 10'd28, 10'd8, 10'd1, 10'd0, 10'd0, 10'd0,
      10'd0},
    '{10'd1, 10'd9, 10'd36, 10'd84, 10'd126, 10'd126, 10'd84, 10'd36, 10'd9, 10'd1, 10'd0,
      10'd0, 10'd0},
    '{10'd1, 10'd10, 10'd45, 10'd120, 10'd210, 10'd252, 10'd210, 10'd120, 10'd45, 10'd10,
      10'd1, 10'd0, 10'd0},
    '{10'd1, 10'd11, 10'd55, 10'd165, 10'd330, 10'd462, 10'd462, 10'd330, 10'd165, 10'd55,
      10'd11, 10'd1, 10'd0},
    '{10'd1, 10'd12, 10'd66, 10'd220, 10'd495, 10'd792, 10'd924, 10'd792, 10'd495, 10'd220,
      10'd66, 10'd12, 10'd1}
  };

  // request beat
  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [INDEX_W-1:0]        sample_index;
  } req_t;

  // response beat
  typedef struct packed {
    logic signed [COORD_W-1:0] curve_x;
    logic signed [COORD_W-1:0] curve_y;
    logic [STATUS_W-1:0]       status;
  } rsp_t;

endpackage

`default_nettype wire

/* design/bezier_curve_evaluator_unit.sv */
// Append and remove take effect at the accepting edge and give no beat; req_ready stays high.
// Evaluate with n + 1 points runs the divider, the powers of 1-t, then per point the weight
// and sum states, then loads the output register; rsp_valid rises and req_ready returns
// together. Errors go straight to the output register state and give their beat from
// there. req_ready is high only while idle; a held beat stalls it.
// Reset (rst, synchronous): point list empty, sample_steps = 100, no beat out.
// Bezier curve evaluator top level: point list, sequencer, shared multiplier,
// restoring divider and output register. Depends on bce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bezier_curve_evaluator_unit #(
  parameter int MAX_POINTS = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  output logic                                 req_ready,
  input  wire bce_pkg::req_t                   req,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_ready,
  output bce_pkg::rsp_t                        rsp,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bce_pkg::STEPS_W-1:0]     cfg_data
);

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int Q_W   = bce_pkg::ACC_W - 16;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIV   = 9'b000000010,
    S_UPOW  = 9'b000000100,
    S_WMUL  = 9'b000001000,
    S_WBIN  = 9'b000010000,
    S_PX    = 9'b000100000,
    S_PY    = 9'b001000000,
    S_TNEXT = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;

  // control registers
  logic [CNT_W-1:0]               point_count;
  logic [bce_pkg::STEPS_W-1:0]    sample_steps;
  logic [IDX_W-1:0]               step_cnt;
  logic [IDX_W-1:0]               n_deg;
  logic [bce_pkg::DIV_CNT_W-1:0]  div_cnt;

  // point store
  logic signed [bce_pkg::COORD_W-1:0] ctrl_x [MAX_POINTS];
  logic signed [bce_pkg::COORD_W-1:0] ctrl_y [MAX_POINTS];

  // datapath registers
  logic [bce_pkg::Q16_W-1:0]          upow [MAX_POINTS];
  logic [bce_pkg::Q16_W-1:0]          up_cur;
  logic [bce_pkg::Q16_W-1:0]          tp;
  logic [bce_pkg::Q16_W-1:0]          mr;
  logic [bce_pkg::MUL_A_W-1:0]        w;
  logic signed [bce_pkg::PROD_W-1:0]  prod;
  logic signed [bce_pkg::ACC_W-1:0]   accx;
  logic signed [bce_pkg::ACC_W-1:0]   accy;
  logic [bce_pkg::STATUS_W-1:0]       res_status;
  logic [bce_pkg::STEPS_W-1:0]        div_s;
  logic [bce_pkg::STEPS_W-1:0]        rem;
  logic [bce_pkg::Q16_W-1:0]          quo;

  // combinational
  logic                               req_fire;
  logic                               rsp_load;
  logic                               list_full;
  logic [bce_pkg::STEPS_W-1:0]        s_eff;
  logic [bce_pkg::NUM_W-1:0]          num;
  logic                               few_points;
  logic                               bad_index;
  logic [IDX_W-1:0]                   wr_idx;
  logic [bce_pkg::STEPS_W:0]          rem2;
  logic                               div_ge;
  logic [bce_pkg::STEPS_W-1:0]        rem_next;
  logic [bce_pkg::Q16_W-1:0]          u_q16;
  logic [bce_pkg::MUL_A_W-1:0]        mul_a;
  logic signed [bce_pkg::MUL_B_W-1:0] mul_b;
  logic signed [bce_pkg::MUL_W-1:0]   mul_out;
  logic [bce_pkg::MUL_W-1:0]          mul_rnd;
  logic [bce_pkg::Q16_W-1:0]          q16_res;
  logic [bce_pkg::BINOM_W-1:0]        binom;
  logic signed [bce_pkg::ACC_W-1:0]   prod_ext;

  // round half up, drop 16 fraction bits, clamp to 16 bits
  function automatic logic signed [bce_pkg::COORD_W-1:0] sat_round(
    input logic signed [bce_pkg::ACC_W-1:0] acc
  );
    logic signed [bce_pkg::ACC_W-1:0] a;
    logic signed [Q_W-1:0]            q;
    a = acc + bce_pkg::ACC_W'(bce_pkg::RND_HALF);
    q = $signed(a[bce_pkg::ACC_W-1:16]);
    if (q > Q_W'(32767)) begin
      sat_round = 16'sh7fff;
    end else if (q < Q_W'(-32768)) begin
      sat_round = 16'sh8000;
    end else begin
      sat_round = q[bce_pkg::COORD_W-1:0];
    end
  endfunction

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign req_fire  = req_valid && req_ready;
  assign rsp_load  = (state == S_OUT) && (!rsp_valid || rsp_ready);

  assign list_full  = (point_count >= CNT_W'(MAX_POINTS));
  assign wr_idx     = point_count[IDX_W-1:0];
  assign s_eff      = (sample_steps == '0) ? bce_pkg::STEPS_W'(1) : sample_steps;
  assign few_points = (point_count < CNT_W'(2));
  assign bad_index  = (req.sample_index > s_eff);
  assign num        = {req.sample_index, 16'b0} + bce_pkg::NUM_W'(s_eff >> 1);

  // one restoring divide step per cycle
  assign rem2     = {rem, quo[bce_pkg::Q16_W-1]};
  assign div_ge   = (rem2 >= {1'b0, div_s});
  assign rem_next = div_ge ? bce_pkg::STEPS_W'(rem2 - {1'b0, div_s})
                           : rem2[bce_pkg::STEPS_W-1:0];

  assign u_q16 = bce_pkg::Q16_ONE - quo;
  assign binom = bce_pkg::BINOM_TAB[bce_pkg::BINOM_IDX_W'(n_deg)]
                                   [bce_pkg::BINOM_IDX_W'(step_cnt)];

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_UPOW: begin
        mul_a = bce_pkg::MUL_A_W'(up_cur);
        mul_b = $signed(bce_pkg::MUL_B_W'(u_q16));
      end
      S_WMUL: begin
        mul_a = bce_pkg::MUL_A_W'(tp);
        mul_b = $signed(bce_pkg::MUL_B_W'(upow[n_deg - step_cnt]));
      end
      S_WBIN: begin
        mul_a = bce_pkg::MUL_A_W'(mr);
        mul_b = $signed(bce_pkg::MUL_B_W'(binom));
      end
      S_PX: begin
        mul_a = w;
        mul_b = bce_pkg::MUL_B_W'(ctrl_x[step_cnt]);
      end
      S_PY: begin
        mul_a = w;
        mul_b = bce_pkg::MUL_B_W'(ctrl_y[step_cnt]);
      end
      S_TNEXT: begin
        mul_a = bce_pkg::MUL_A_W'(tp);
        mul_b = $signed(bce_pkg::MUL_B_W'(quo));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_out  = $signed({1'b0, mul_a}) * mul_b;
  assign mul_rnd  = mul_out + bce_pkg::MUL_W'(bce_pkg::RND_HALF);
  assign q16_res  = mul_rnd[bce_pkg::Q16_W+15:16];
  assign prod_ext = bce_pkg::ACC_W'(prod);

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      point_count  <= '0;
      sample_steps <= bce_pkg::STEPS_RESET;
      step_cnt     <= '0;
      n_deg        <= '0;
      div_cnt      <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sample_steps <= cfg_data;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            unique case (req.op)
              bce_pkg::OP_APPEND: begin
                if (!list_full) begin
                  point_count <= point_count + CNT_W'(1);
                end
              end
              bce_pkg::OP_REMOVE: begin
                if (point_count != '0) begin
                  point_count <= point_count - CNT_W'(1);
                end
              end
              bce_pkg::OP_EVAL: begin
                n_deg   <= IDX_W'(point_count - CNT_W'(1));
                div_cnt <= '0;
                if (few_points || bad_index) begin
                  state <= S_OUT;
                end else begin
                  state <= S_DIV;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          div_cnt <= div_cnt + bce_pkg::DIV_CNT_W'(1);
          if (div_cnt == bce_pkg::DIV_CNT_W'(bce_pkg::DIV_STEPS - 1)) begin
            step_cnt <= IDX_W'(1);
            state    <= S_UPOW;
          end
        end
        S_UPOW: begin
          if (step_cnt == n_deg) begin
            step_cnt <= '0;
            state    <= S_WMUL;
          end else begin
            step_cnt <= step_cnt + IDX_W'(1);
          end
        end
        S_WMUL:  state <= S_WBIN;
        S_WBIN:  state <= S_PX;
        S_PX:    state <= S_PY;
        S_PY:    state <= S_TNEXT;
        S_TNEXT: begin
          if (step_cnt == n_deg) begin
            state <= S_OUT;
          end else begin
            step_cnt <= step_cnt + IDX_W'(1);
            state    <= S_WMUL;
          end
        end
        S_OUT: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    // point store write
    if (req_fire && req.op == bce_pkg::OP_APPEND && !list_full) begin
      ctrl_x[wr_idx] <= req.point_x;
      ctrl_y[wr_idx] <= req.point_y;
    end
    // evaluate start: status, divider load, clear sums
    if (req_fire && req.op == bce_pkg::OP_EVAL) begin
      if (few_points) begin
        res_status <= bce_pkg::ST_FEW_POINTS;
      end else if (bad_index) begin
        res_status <= bce_pkg::ST_BAD_INDEX;
      end else begin
        res_status <= bce_pkg::ST_OK;
      end
      div_s <= s_eff;
      rem   <= bce_pkg::STEPS_W'(num[bce_pkg::NUM_W-1:bce_pkg::Q16_W]);
      quo   <= num[bce_pkg::Q16_W-1:0];
      accx  <= '0;
      accy  <= '0;
    end
    if (state == S_DIV) begin
      rem <= rem_next;
      quo <= {quo[bce_pkg::Q16_W-2:0], div_ge};
      if (div_cnt == bce_pkg::DIV_CNT_W'(bce_pkg::DIV_STEPS - 1)) begin
        upow[0] <= bce_pkg::Q16_ONE;
        up_cur  <= bce_pkg::Q16_ONE;
      end
    end
    // powers of (1 - t)
    if (state == S_UPOW) begin
      upow[step_cnt] <= q16_res;
      up_cur         <= q16_res;
      if (step_cnt == n_deg) begin
        tp <= bce_pkg::Q16_ONE;
      end
    end
    if (state == S_WMUL) begin
      mr <= q16_res;
    end
    if (state == S_WBIN) begin
      w <= mul_out[bce_pkg::MUL_A_W-1:0];
    end
    if (state == S_PX) begin
      prod <= mul_out[bce_pkg::PROD_W-1:0];
    end
    if (state == S_PY) begin
      prod <= mul_out[bce_pkg::PROD_W-1:0];
      accx <= accx + prod_ext;
    end
    if (state == S_TNEXT) begin
      accy <= accy + prod_ext;
      tp   <= q16_res;
    end
    // output register
    if (rsp_load) begin
      rsp.status <= res_status;
      if (res_status == bce_pkg::ST_OK) begin
        rsp.curve_x <= sat_round(accx);
        rsp.curve_y <= sat_round(accy);
      end else begin
        rsp.curve_x <= '0;
        rsp.curve_y <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CNT_W'(MAX_POINTS))
    else $error("point count beyond list size");

  a_list_frozen: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> $stable(point_count))
    else $error("point list changed during evaluation");

  a_t_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPOW) |-> (quo <= bce_pkg::Q16_ONE))
    else $error("divider result above one");

  a_ok_after_sum: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && res_status == bce_pkg::ST_OK)
      |-> ($past(state) == S_TNEXT || $past(state) == S_OUT))
    else $error("ok result without a finished sum");

  a_rsp_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_OUT))
    else $error("response beat raised outside output state");
`endif

endmodule

`default_nettype wire

/* dv/bezier_curve_evaluator_unit_tb.sv */
// Self-checking testbench for bezier_curve_evaluator_unit: directed table then random
// point-list traffic over several sample_steps settings, checked against a local predictor.
// Depends on bce_pkg and the bezier_curve_evaluator_unit RTL.
`timescale 1ns / 1ps

module bezier_curve_evaluator_unit_tb;

  localparam int NUM_SLOTS       = 8;
  localparam int CLK_HALF        = 10;
  localparam int RESET_CYCLES    = 6;
  localparam int QUIET_CYCLES    = 80;
  localparam int RSP_HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int NUM_PHASES      = 7;
  localparam int PHASE_BEATS     = 272;
  localparam logic [bce_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  // one directed row: request plus an optional hand-written response
  typedef struct {
    bce_pkg::req_t item;
    bit            typed;
    bce_pkg::rsp_t want;
  } stim_row_t;

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        req_valid = 1'b0;
  logic                        req_ready;
  bce_pkg::req_t               req       = '0;
  logic                        rsp_valid;
  logic                        rsp_ready = 1'b0;
  bce_pkg::rsp_t               rsp;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [bce_pkg::STEPS_W-1:0] cfg_data  = '0;

  // predictor state
  shortint                     ctrl_x [NUM_SLOTS];
  shortint                     ctrl_y [NUM_SLOTS];
  int                          fill;
  logic [bce_pkg::STEPS_W-1:0] steps_reg;

  bce_pkg::rsp_t pending_points [$];
  stim_row_t     directed_rows [$];
  int            fail_count    = 0;
  int            cycle_count   = 0;
  int            req_idle_pct  = 0;
  int            rsp_idle_pct  = 0;
  int            hold_left     = 0;
  bit            hold_rsp_req  = 1'b0;

  bezier_curve_evaluator_unit #(
    .MAX_POINTS(NUM_SLOTS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Predict the effect of one accepted request; returns 1 when a beat is due.
  function automatic bit curve_predict(input bce_pkg::req_t item, output bce_pkg::rsp_t res);
    longint unsigned t, u, tp, up, w, binom;
    longint          acc_x, acc_y, q_x, q_y;
    int              s, n, j, i;
    res = '0;
    case (item.op)
      bce_pkg::OP_APPEND: begin
        if (fill < NUM_SLOTS) begin
          ctrl_x[fill] = item.point_x;
          ctrl_y[fill] = item.point_y;
          fill++;
        end
        return 1'b0;
      end
      bce_pkg::OP_REMOVE: begin
        if (fill > 0) fill--;
        return 1'b0;
      end
      bce_pkg::OP_EVAL: ;
      default: return 1'b0;
    endcase
    if (fill < 2) begin
      res.status = bce_pkg::ST_FEW_POINTS;
      return 1'b1;
    end
    s = (steps_reg == 0) ? 1 : int'(steps_reg);
    if (int'(item.sample_index) > s) begin
      res.status = bce_pkg::ST_BAD_INDEX;
      return 1'b1;
    end
    // t in Q1.16, rounded to nearest
    t = (longint'(item.sample_index) * 65536 + s / 2) / s;
    u = 65536 - t;
    n = fill - 1;
    binom = 1;
    acc_x = 0;
    acc_y = 0;
    for (j = 0; j <= n; j++) begin
      tp = 65536;
      for (i = 0; i < j; i++) tp = (tp * t + 32768) >> 16;
      up = 65536;
      for (i = 0; i < n - j; i++) up = (up * u + 32768) >> 16;
      w = ((tp * up + 32768) >> 16) * binom;
      acc_x += longint'(w) * ctrl_x[j];
      acc_y += longint'(w) * ctrl_y[j];
      binom = binom * (n - j) / (j + 1);
    end
    // round half up, then clamp to 16 bits
    q_x = (acc_x + 32768) >>> 16;
    q_y = (acc_y + 32768) >>> 16;
    if (q_x > 32767) q_x = 32767;
    if (q_x < -32768) q_x = -32768;
    if (q_y > 32767) q_y = 32767;
    if (q_y < -32768) q_y = -32768;
    res.curve_x = q_x[bce_pkg::COORD_W-1:0];
    res.curve_y = q_y[bce_pkg::COORD_W-1:0];
    res.status  = bce_pkg::ST_OK;
    return 1'b1;
  endfunction

  function automatic stim_row_t plain(input logic [bce_pkg::OP_W-1:0] op,
                                      input logic signed [bce_pkg::COORD_W-1:0] x,
                                      input logic signed [bce_pkg::COORD_W-1:0] y,
                                      input logic [bce_pkg::INDEX_W-1:0] k);
    stim_row_t r;
    r.item.op           = op;
    r.item.point_x      = x;
    r.item.point_y      = y;
    r.item.sample_index = k;
    r.typed             = 1'b0;
    r.want              = '0;
    return r;
  endfunction

  function automatic stim_row_t known(input logic [bce_pkg::OP_W-1:0] op,
                                      input logic [bce_pkg::INDEX_W-1:0] k,
                                      input logic signed [bce_pkg::COORD_W-1:0] cx,
                                      input logic signed [bce_pkg::COORD_W-1:0] cy,
                                      input logic [bce_pkg::STATUS_W-1:0] st);
    stim_row_t r;
    r              = plain(op, 16'sd0, 16'sd0, k);
    r.typed        = 1'b1;
    r.want.curve_x = cx;
    r.want.curve_y = cy;
    r.want.status  = st;
    return r;
  endfunction

  // append one row to the directed table
  task automatic add_row(input stim_row_t r);
    directed_rows = {directed_rows, r};
  endtask

  // mostly full-range values, with the corners weighted up
  function automatic logic signed [bce_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return 16'sd0;
      3:       return -16'sd1;
      default: return bce_pkg::COORD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Offer one request beat, wait for it to be taken, then predict.
  task automatic offer_request(input bce_pkg::req_t item, input bit typed,
                               input bce_pkg::rsp_t want);
    bce_pkg::rsp_t predicted;
    bit            has_rsp;
    while ($urandom_range(0, 99) < req_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    has_rsp = curve_predict(item, predicted);
    if (typed) predicted = want;
    if (has_rsp) pending_points = {pending_points, predicted};
  endtask

  // Stop sending and wait for every outstanding beat, then some quiet cycles.
  task automatic drain_results(input int quiet);
    req_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (quiet) @(posedge clk);
  endtask

  task automatic write_steps(input logic [bce_pkg::STEPS_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    steps_reg = value;
  endtask

  // Response side: check each beat taken, then choose next cycle's ready.
  always @(posedge clk) begin : rsp_monitor
    bce_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected beat x=%0d y=%0d status=%0d", $time,
                 rsp.curve_x, rsp.curve_y, rsp.status);
        fail_count++;
      end else begin
        want = pending_points.pop_front();
        if (rsp.curve_x !== want.curve_x) begin
          $display("%0t: curve_x expected %0d actual %0d", $time, want.curve_x, rsp.curve_x);
          fail_count++;
        end
        if (rsp.curve_y !== want.curve_y) begin
          $display("%0t: curve_y expected %0d actual %0d", $time, want.curve_y, rsp.curve_y);
          fail_count++;
        end
        if (rsp.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, rsp.status);
          fail_count++;
        end
      end
    end
    if (hold_rsp_req) begin
      hold_left    = RSP_HOLD_CYCLES;
      hold_rsp_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // Main stimulus
  initial begin : stimulus
    bce_pkg::req_t cand;
    int            done, mode, eval_max;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      ctrl_x[i] = '0;
      ctrl_y[i] = '0;
    end
    fill      = 0;
    steps_reg = bce_pkg::STEPS_RESET;

    // directed rows, run at the reset value of sample_steps
    add_row(known(bce_pkg::OP_EVAL, 10'd0, 16'sd0, 16'sd0, bce_pkg::ST_FEW_POINTS));
    add_row(plain(bce_pkg::OP_REMOVE, 16'sd0, 16'sd0, 10'd0));
    add_row(plain(bce_pkg::OP_APPEND, 16'sd32767, 16'sd32767, 10'd0));
    // too few points wins over an index beyond range
    add_row(known(bce_pkg::OP_EVAL, 10'd1023, 16'sd0, 16'sd0, bce_pkg::ST_FEW_POINTS));
    add_row(plain(bce_pkg::OP_APPEND, -16'sd32768, -16'sd32768, 10'd1023));
    add_row(known(bce_pkg::OP_EVAL, 10'd0, 16'sd32767, 16'sd32767, bce_pkg::ST_OK));
    add_row(known(bce_pkg::OP_EVAL, 10'd100, -16'sd32768, -16'sd32768, bce_pkg::ST_OK));
    add_row(known(bce_pkg::OP_EVAL, 10'd101, 16'sd0, 16'sd0, bce_pkg::ST_BAD_INDEX));
    add_row(known(bce_pkg::OP_EVAL, 10'd1023, 16'sd0, 16'sd0, bce_pkg::ST_BAD_INDEX));
    add_row(plain(bce_pkg::OP_EVAL, 16'sd0, 16'sd0, 10'd50));
    add_row(plain(OP_UNUSED, 16'sd1234, -16'sd1234, 10'd7));
    add_row(plain(bce_pkg::OP_APPEND, 16'sd0, 16'sd0, 10'd0));
    add_row(plain(bce_pkg::OP_APPEND, -16'sd1, -16'sd1, 10'd0));
    add_row(plain(bce_pkg::OP_APPEND, 16'sd32767, -16'sd32768, 10'd0));
    add_row(plain(bce_pkg::OP_APPEND, -16'sd32768, 16'sd32767, 10'd0));
    add_row(plain(bce_pkg::OP_APPEND, 16'sh5555, -16'sd21846, 10'd0));
    add_row(plain(bce_pkg::OP_APPEND, 16'sd8192, -16'sd8192, 10'd0));
    // list is full: this point is dropped
    add_row(plain(bce_pkg::OP_APPEND, 16'sd1111, -16'sd1111, 10'd0));
    add_row(plain(bce_pkg::OP_EVAL, 16'sd0, 16'sd0, 10'd37));
    add_row(plain(bce_pkg::OP_EVAL, 16'sd0, 16'sd0, 10'd100));
    add_row(plain(bce_pkg::OP_REMOVE, 16'sd0, 16'sd0, 10'd0));
    add_row(plain(bce_pkg::OP_EVAL, 16'sd0, 16'sd0, 10'd1));

    req_idle_pct = 26;
    rsp_idle_pct = 52;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      offer_request(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    // random phases, each with its own sample_steps and idling pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain_results(QUIET_CYCLES);
        case (p)
          1:       write_steps(10'd1);
          2:       write_steps(10'd0);
          3:       write_steps(10'd1023);
          4:       write_steps(10'd3);
          5:       write_steps(bce_pkg::STEPS_W'($urandom_range(2, 1022)));
          default: write_steps(bce_pkg::STEPS_RESET);
        endcase
      end
      mode = p % 3;
      req_idle_pct = (mode == 0) ? 26 : (mode == 1) ? 52 : 0;
      rsp_idle_pct = (mode == 0) ? 52 : (mode == 1) ? 26 : 0;
      eval_max = (steps_reg == 0) ? 1 : int'(steps_reg);
      done = 0;
      while (done < PHASE_BEATS) begin
        // long receiver stall with the sender still pushing
        if (p == 5 && done == 100 && hold_left == 0) hold_rsp_req = 1'b1;
        // sender holds back until the block has emptied
        if (p == 2 && done == 130) drain_results(0);
        cand.point_x      = rand_coord();
        cand.point_y      = rand_coord();
        cand.sample_index = ($urandom_range(0, 99) < 85)
                            ? bce_pkg::INDEX_W'($urandom_range(0, eval_max))
                            : bce_pkg::INDEX_W'($urandom_range(0, 1023));
        if ($urandom_range(0, 99) < 4) begin
          cand.op = OP_UNUSED;
        end else if (fill < 2) begin
          case ($urandom_range(0, 9))
            0:       cand.op = bce_pkg::OP_REMOVE;
            1, 2:    cand.op = bce_pkg::OP_EVAL;
            default: cand.op = bce_pkg::OP_APPEND;
          endcase
        end else begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: cand.op = bce_pkg::OP_APPEND;
            5, 6, 7:       cand.op = bce_pkg::OP_REMOVE;
            default:       cand.op = bce_pkg::OP_EVAL;
          endcase
        end
        offer_request(cand, 1'b0, '0);
        done++;
      end
    end

    drain_results(QUIET_CYCLES);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
